// ===== design/size_class_node_allocator_macros.svh =====
// Assertion macros for the size-class node allocator.
// Included by the allocator top level; no other dependencies.
`ifndef SIZE_CLASS_NODE_ALLOCATOR_MACROS_SVH
`define SIZE_CLASS_NODE_ALLOCATOR_MACROS_SVH

`ifndef SYNTH
// Property that must hold at every clock edge outside reset
`define SCNA_ASSERT(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) else $error(msg);
// Condition that implies a consequence in the next cycle
`define SCNA_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);
`else
`define SCNA_ASSERT(lbl, ck, rn, prop, msg)
`define SCNA_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg)
`endif

`endif

// ===== design/scna_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the size-class node allocator.
// No dependencies.
package scna_pkg;

  localparam int MEM_WORDS   = 65536;
  localparam int NUM_CLASSES = 12;
  localparam int ADDR_W      = 16;
  localparam int ADDR_SPACE  = 1 << ADDR_W;
  localparam int USABLE      = (MEM_WORDS > ADDR_SPACE) ? ADDR_SPACE : MEM_WORDS;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    STAT_OK            = 3'd0,
    STAT_OUT_OF_MEMORY = 3'd1,
    STAT_NOT_RECLAIMED = 3'd2,
    STAT_PROTECTED     = 3'd3,
    STAT_DOUBLE_FREE   = 3'd4,
    STAT_SIZE_MISMATCH = 3'd5,
    STAT_HEAD_IN_USE   = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    op_t         opcode;
    logic [6:0]  block_size;
    logic [15:0] block_address;
  } in_item_t;

  typedef struct packed {
    logic [15:0] address;
    status_t     status;
    logic [16:0] words_in_use;
  } out_item_t;

  // Initial carve region size for a given reserved top address
  function automatic logic [16:0] carve_size_init(input logic [15:0] reserved);
    logic [16:0] lo;
    logic [16:0] top;
    lo  = {1'b0, reserved} + 17'd1;
    top = 17'(USABLE);
    carve_size_init = (top > lo) ? (top - lo) : 17'd0;
  endfunction

endpackage

// ===== design/size_class_node_allocator.sv =====
`timescale 1ns / 1ps
// Size-class node allocator: free chains per size class, carve region, word tags.
// Depends on scna_pkg and size_class_node_allocator_macros.svh.
// The result is registered in the output register after the captured request and read data, once the output is free.
// Items are taken one at a time: read of tag/link memories, then modify-write.
// Reset and every reserved_words write start a clearing pass over the 65536-entry
// tag memory, one entry a cycle, during which no item is taken.
// The single-port tag and link memories set this one-at-a-time pace.
`include "size_class_node_allocator_macros.svh"

module size_class_node_allocator #(
  parameter int NUM_CLASSES = scna_pkg::NUM_CLASSES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  scna_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output scna_pkg::out_item_t  out_data
);

  localparam int          HIDX_W = $clog2(NUM_CLASSES);
  localparam logic [6:0]  NC_L   = 7'(NUM_CLASSES);
  localparam int          DEPTH  = scna_pkg::ADDR_SPACE;

  scna_pkg::state_t state_r, state_nxt;

  // Storage
  logic signed [7:0] tag_mem  [DEPTH];
  logic [15:0]       link_mem [DEPTH];
  logic [15:0]       heads_r  [NUM_CLASSES];

  logic [15:0] reserved_r;
  logic [15:0] carve_base_r;
  logic [16:0] carve_size_r, carve_size_nxt;
  logic [16:0] used_r, used_nxt;
  logic [15:0] clr_cnt_r;

  // Captured operation
  scna_pkg::op_t     op_r;
  logic [6:0]        s_r;
  logic [15:0]       p_r;
  logic [15:0]       addr_r;
  logic [15:0]       head_q_r;
  logic [HIDX_W-1:0] hidx_r;
  logic signed [7:0] tag_rdata_r;
  logic [15:0]       link_rdata_r;

  logic               out_valid_r;
  scna_pkg::out_item_t out_data_r;

  // Control
  logic in_accept, exec_go, clr_we;

  // Issue-side lookup
  logic              chain_in;
  logic [HIDX_W-1:0] in_hidx;
  logic [15:0]       in_head;
  logic [15:0]       rd_addr;

  // Execute-side results
  scna_pkg::status_t ex_status;
  logic [15:0]       ex_addr;
  logic              ex_tag_we, ex_link_we, ex_head_we;
  logic [15:0]       ex_tag_addr, ex_head_wdata;
  logic signed [7:0] ex_tag_wdata;
  logic [16:0]       cs_diff;
  logic [15:0]       carve_addr;
  logic              chain_ex;

  // Memory ports
  logic              tag_we, tag_re, link_we, link_re;
  logic [15:0]       tag_addr, link_addr;
  logic signed [7:0] tag_wdata;

  // Next state
  always_comb begin
    state_nxt = state_r;
    if (cfg_we) begin
      state_nxt = scna_pkg::S_CLEAR;
    end else begin
      case (state_r)
        scna_pkg::S_CLEAR: if (&clr_cnt_r) state_nxt = scna_pkg::S_IDLE;
        scna_pkg::S_IDLE:  if (in_accept) state_nxt = scna_pkg::S_EXEC;
        scna_pkg::S_EXEC:  if (exec_go) state_nxt = scna_pkg::S_IDLE;
        default:           state_nxt = scna_pkg::S_CLEAR;
      endcase
    end
  end

  // State outputs
  always_comb begin
    in_stall  = (state_r != scna_pkg::S_IDLE);
    in_accept = in_valid && (state_r == scna_pkg::S_IDLE);
    exec_go   = (state_r == scna_pkg::S_EXEC) && (!out_valid_r || !out_stall);
    clr_we    = (state_r == scna_pkg::S_CLEAR);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= scna_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      clr_cnt_r <= '0;
    end else if (clr_we) begin
      clr_cnt_r <= clr_cnt_r + 16'd1;
    end
  end

  // Issue: chain head lookup and read address
  always_comb begin
    chain_in = (in_data.block_size < NC_L);
    in_hidx  = in_data.block_size[HIDX_W-1:0];
    in_head  = chain_in ? heads_r[in_hidx] : 16'd0;
    rd_addr  = (in_data.opcode == scna_pkg::OP_FREE) ? in_data.block_address : in_head;
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r     <= in_data.opcode;
      s_r      <= in_data.block_size;
      p_r      <= in_data.block_address;
      addr_r   <= rd_addr;
      head_q_r <= in_head;
      hidx_r   <= in_hidx;
    end
  end

  // Execute: decide outcome from read data
  always_comb begin
    chain_ex      = (s_r < NC_L);
    cs_diff       = carve_size_r - {10'd0, s_r};
    carve_addr    = carve_base_r + cs_diff[15:0];
    ex_status     = scna_pkg::STAT_OK;
    ex_addr       = 16'd0;
    ex_tag_we     = 1'b0;
    ex_tag_addr   = addr_r;
    ex_tag_wdata  = $signed({1'b0, s_r});
    ex_link_we    = 1'b0;
    ex_head_we    = 1'b0;
    ex_head_wdata = link_rdata_r;
    used_nxt      = used_r;
    carve_size_nxt = carve_size_r;
    if (op_r == scna_pkg::OP_ALLOC) begin
      if (s_r == 7'd0) begin
        ex_status = scna_pkg::STAT_SIZE_MISMATCH;
      end else if (head_q_r != 16'd0) begin
        // pop: the head leaves the chain even when it turns out to be in use
        ex_head_we = 1'b1;
        if (tag_rdata_r >= 0) begin
          ex_status = scna_pkg::STAT_HEAD_IN_USE;
        end else begin
          ex_tag_we = 1'b1;
          ex_addr   = addr_r;
          used_nxt  = used_r + {10'd0, s_r};
        end
      end else if (carve_size_r > {10'd0, s_r}) begin
        carve_size_nxt = cs_diff;
        ex_tag_we      = 1'b1;
        ex_tag_addr    = carve_addr;
        ex_addr        = carve_addr;
        used_nxt       = used_r + {10'd0, s_r};
      end else begin
        ex_status = scna_pkg::STAT_OUT_OF_MEMORY;
      end
    end else begin
      if (!chain_ex) begin
        ex_status = scna_pkg::STAT_NOT_RECLAIMED;
      end else if (p_r <= reserved_r) begin
        ex_status = scna_pkg::STAT_PROTECTED;
      end else if (tag_rdata_r <= 0) begin
        ex_status = scna_pkg::STAT_DOUBLE_FREE;
      end else if (tag_rdata_r != $signed({1'b0, s_r})) begin
        ex_status = scna_pkg::STAT_SIZE_MISMATCH;
      end else begin
        ex_tag_we     = 1'b1;
        ex_tag_wdata  = -tag_rdata_r;
        ex_link_we    = 1'b1;
        ex_head_we    = 1'b1;
        ex_head_wdata = p_r;
        used_nxt      = used_r - {10'd0, s_r};
      end
    end
  end

  // Memory port muxing
  always_comb begin
    tag_re    = in_accept;
    tag_we    = clr_we || (exec_go && ex_tag_we);
    tag_wdata = clr_we ? 8'sd0 : ex_tag_wdata;
    if (clr_we) begin
      tag_addr = clr_cnt_r;
    end else if (state_r == scna_pkg::S_EXEC) begin
      tag_addr = ex_tag_addr;
    end else begin
      tag_addr = rd_addr;
    end
    link_re   = in_accept;
    link_we   = exec_go && ex_link_we;
    link_addr = (state_r == scna_pkg::S_EXEC) ? addr_r : rd_addr;
  end

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[tag_addr] <= tag_wdata;
    end
    if (tag_re) begin
      tag_rdata_r <= tag_mem[tag_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_addr] <= head_q_r;
    end
    if (link_re) begin
      link_rdata_r <= link_mem[link_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        heads_r[i] <= 16'd0;
      end
    end else if (exec_go && ex_head_we) begin
      heads_r[hidx_r] <= ex_head_wdata;
    end
  end

  // Region registers; a reserved_words write reinitialises them
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reserved_r   <= 16'd0;
      carve_base_r <= 16'd1;
      carve_size_r <= scna_pkg::carve_size_init(16'd0);
      used_r       <= 17'd0;
    end else if (cfg_we) begin
      reserved_r   <= cfg_wdata;
      carve_base_r <= cfg_wdata + 16'd1;
      carve_size_r <= scna_pkg::carve_size_init(cfg_wdata);
      used_r       <= 17'd0;
    end else if (exec_go) begin
      carve_size_r <= carve_size_nxt;
      used_r       <= used_nxt;
    end
  end

  // Output register: hold until transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      out_data_r.address      <= ex_addr;
      out_data_r.status       <= ex_status;
      out_data_r.words_in_use <= used_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SCNA_ASSERT(a_port_exclusive, clk, rst_n, !(tag_we && tag_re), "tag memory read and written in one cycle")
  `SCNA_ASSERT_NEXT(a_accept_exec, clk, rst_n, in_accept && !cfg_we, state_r == scna_pkg::S_EXEC, "accepted item did not enter execute")
  `SCNA_ASSERT(a_out_from_exec, clk, rst_n, !$rose(out_valid_r) || $past(exec_go), "result appeared without an execute step")
  `SCNA_ASSERT(a_used_stable, clk, rst_n, !($past(rst_n) && !$past(exec_go) && !$past(cfg_we)) || $stable(used_r), "usage count changed outside an execute step")

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for size_class_node_allocator: directed and random allocate/free traffic.
// Depends on scna_pkg and the allocator RTL; results are predicted by the tracker class below.
module tb;

  typedef struct {
    bit [15:0] addr;
    bit [6:0]  size;
  } block_t;

  // Mirrors the allocator's chains, tags and carve region; queues predicted results
  class alloc_tracker;
    bit [15:0]           reserved;
    bit [15:0]           heads [scna_pkg::NUM_CLASSES];
    bit [15:0]           links [scna_pkg::ADDR_SPACE];
    byte                 tags [scna_pkg::ADDR_SPACE];
    bit [15:0]           carve_base;
    bit [16:0]           carve_size;
    bit [16:0]           used;
    scna_pkg::out_item_t awaited[$];
    block_t              live[$];
    block_t              recent[$];
    bit [15:0]           last_grant;
    int unsigned         errors;
    int unsigned         reported;
    int unsigned         requests;
    int unsigned         settings;
    int unsigned         status_seen [8];

    function void reinit(bit [15:0] rsv);
      int lo;
      reserved = rsv;
      lo = int'(rsv) + 1;
      foreach (heads[i]) heads[i] = '0;
      foreach (tags[i]) tags[i] = 0;
      carve_base = 16'(lo);
      carve_size = (scna_pkg::USABLE > lo) ? 17'(scna_pkg::USABLE - lo) : 17'd0;
      used = '0;
      live.delete();
      recent.delete();
      settings++;
    endfunction

    function void forget_recent(bit [15:0] a);
      for (int i = recent.size() - 1; i >= 0; i--)
        if (recent[i].addr == a) recent.delete(i);
    endfunction

    function void note_request(scna_pkg::in_item_t it);
      scna_pkg::out_item_t r;
      int                  s;
      bit [15:0]           p;
      bit [15:0]           hd;
      block_t              b;
      s = int'(it.block_size);
      p = it.block_address;
      r.address = '0;
      if (it.opcode == scna_pkg::OP_ALLOC) begin
        if (s == 0) begin
          r.status = scna_pkg::STAT_SIZE_MISMATCH;
        end else if (s < scna_pkg::NUM_CLASSES && heads[s] != 0) begin
          hd = heads[s];
          heads[s] = links[hd];
          if (tags[hd] >= 0) begin
            r.status = scna_pkg::STAT_HEAD_IN_USE;
          end else begin
            tags[hd] = byte'(s);
            used = used + 17'(s);
            r.address = hd;
            r.status = scna_pkg::STAT_OK;
          end
        end else if (carve_size > 17'(s)) begin
          carve_size = carve_size - 17'(s);
          hd = 16'(17'(carve_base) + carve_size);
          tags[hd] = byte'(s);
          used = used + 17'(s);
          r.address = hd;
          r.status = scna_pkg::STAT_OK;
        end else begin
          r.status = scna_pkg::STAT_OUT_OF_MEMORY;
        end
        if (r.status == scna_pkg::STAT_OK) begin
          last_grant = r.address;
          b.addr = r.address;
          b.size = it.block_size;
          live.push_back(b);
          forget_recent(r.address);
        end
      end else begin
        if (s >= scna_pkg::NUM_CLASSES) begin
          r.status = scna_pkg::STAT_NOT_RECLAIMED;
        end else if (p <= reserved) begin
          r.status = scna_pkg::STAT_PROTECTED;
        end else if (tags[p] <= 0) begin
          r.status = scna_pkg::STAT_DOUBLE_FREE;
        end else if (int'(tags[p]) != s) begin
          r.status = scna_pkg::STAT_SIZE_MISMATCH;
        end else begin
          tags[p] = -tags[p];
          links[p] = heads[s];
          heads[s] = p;
          used = used - 17'(s);
          r.status = scna_pkg::STAT_OK;
          for (int i = live.size() - 1; i >= 0; i--)
            if (live[i].addr == p) live.delete(i);
          b.addr = p;
          b.size = it.block_size;
          recent.push_back(b);
          if (recent.size() > 16) void'(recent.pop_front());
        end
      end
      r.words_in_use = used;
      status_seen[r.status]++;
      requests++;
      awaited.push_back(r);
    endfunction

    function void mismatch(string field, logic [16:0] want, logic [16:0] seen);
      errors++;
      if (reported < 60)
        $display("%0t  %s mismatch: expected %0d, got %0d", $time, field, want, seen);
      reported++;
    endfunction

    function void check_response(scna_pkg::out_item_t got);
      scna_pkg::out_item_t want;
      if (awaited.size() == 0) begin
        errors++;
        if (reported < 60)
          $display("%0t  unexpected result: expected none, got addr %0d status %0d words %0d",
                   $time, got.address, got.status, got.words_in_use);
        reported++;
        return;
      end
      want = awaited.pop_front();
      if (got.address !== want.address) mismatch("address", want.address, got.address);
      if (got.status !== want.status) mismatch("status", want.status, got.status);
      if (got.words_in_use !== want.words_in_use)
        mismatch("words_in_use", want.words_in_use, got.words_in_use);
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [15:0]         cfg_wdata;
  logic                in_valid;
  logic                in_stall;
  scna_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_stall;
  scna_pkg::out_item_t out_data;

  alloc_tracker tr;
  int unsigned  send_idle_pct;
  int unsigned  recv_idle_pct;

  size_class_node_allocator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tr.check_response(out_data);
  end

  function automatic scna_pkg::in_item_t make_item(scna_pkg::op_t op, bit [6:0] size,
                                                   bit [15:0] addr);
    scna_pkg::in_item_t it;
    it.opcode = op;
    it.block_size = size;
    it.block_address = addr;
    return it;
  endfunction

  // Mostly sound allocate/free traffic, with a share of misuse mixed in
  function automatic scna_pkg::in_item_t random_request();
    scna_pkg::in_item_t it;
    int unsigned        pick;
    int unsigned        w;
    int unsigned        idx;
    block_t             b;
    it = make_item(scna_pkg::OP_ALLOC, 7'd1, 16'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 45 || tr.live.size() == 0) begin
      w = $urandom_range(0, 99);
      if (w < 80)      it.block_size = 7'($urandom_range(1, scna_pkg::NUM_CLASSES - 1));
      else if (w < 97) it.block_size = 7'($urandom_range(scna_pkg::NUM_CLASSES, 127));
      else             it.block_size = 7'd0;
    end else if (pick < 82) begin
      idx = $urandom_range(0, tr.live.size() - 1);
      b = tr.live[idx];
      it = make_item(scna_pkg::OP_FREE, b.size, b.addr);
    end else begin
      it.opcode = scna_pkg::OP_FREE;
      it.block_size = 7'($urandom);
      case ($urandom_range(0, 3))
        0: ;
        1: if (tr.recent.size() != 0) begin
          b = tr.recent[$urandom_range(0, tr.recent.size() - 1)];
          it.block_address = b.addr;
          it.block_size = b.size;
        end
        2: begin
          b = tr.live[$urandom_range(0, tr.live.size() - 1)];
          it.block_address = b.addr;
          it.block_size = b.size + 7'($urandom_range(1, 126));
        end
        default: it.block_address = 16'($urandom_range(0, tr.reserved));
      endcase
    end
    return it;
  endfunction

  task automatic send_item(input scna_pkg::in_item_t it);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    tr.note_request(it);
  endtask

  // Hold the input idle until every predicted result has been seen
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tr.awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reserved(input bit [15:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    tr.reinit(value);
  endtask

  initial begin
    bit [15:0]   a1;
    bit [15:0]   a11;
    bit [15:0]   a12;
    bit [15:0]   a127;
    bit [15:0]   rsv [3];
    int unsigned count [3];
    int          ph;
    int          i;
    tr = new();
    tr.reinit(16'd0);
    tr.settings = 0;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_stall     = 1'b0;
    send_idle_pct = 21;
    recv_idle_pct = 57;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset setting: no protected region apart from address 0
    send_item(make_item(scna_pkg::OP_ALLOC, 7'd0, 16'hFFFF));
    send_item(make_item(scna_pkg::OP_ALLOC, 7'd1, 16'h0000));
    a1 = tr.last_grant;
    send_item(make_item(scna_pkg::OP_ALLOC, 7'd11, 16'h5555));
    a11 = tr.last_grant;
    send_item(make_item(scna_pkg::OP_ALLOC, 7'd12, 16'hAAAA));
    a12 = tr.last_grant;
    send_item(make_item(scna_pkg::OP_ALLOC, 7'd127, 16'h0000));
    a127 = tr.last_grant;
    send_item(make_item(scna_pkg::OP_FREE, 7'd0, a1));
    send_item(make_item(scna_pkg::OP_FREE, 7'd2, a1));
    send_item(make_item(scna_pkg::OP_FREE, 7'd1, 16'h0000));
    send_item(make_item(scna_pkg::OP_FREE, 7'd12, a12));
    send_item(make_item(scna_pkg::OP_FREE, 7'd127, a127));
    send_item(make_item(scna_pkg::OP_FREE, 7'd1, a1));
    send_item(make_item(scna_pkg::OP_FREE, 7'd1, a1));
    send_item(make_item(scna_pkg::OP_FREE, 7'd11, a11 + 16'd1));
    send_item(make_item(scna_pkg::OP_ALLOC, 7'd1, 16'h0000));
    send_item(make_item(scna_pkg::OP_FREE, 7'd11, a11));
    send_item(make_item(scna_pkg::OP_ALLOC, 7'd11, 16'h0000));
    send_item(make_item(scna_pkg::OP_ALLOC, 7'd11, 16'h0000));
    send_item(make_item(scna_pkg::OP_FREE, 7'd5, 16'h8000));
    drain_results();

    // Reserve of 65534: the carve region keeps its one word, so nothing can be carved
    write_reserved(16'd65534);
    send_item(make_item(scna_pkg::OP_ALLOC, 7'd1, 16'h0000));
    send_item(make_item(scna_pkg::OP_ALLOC, 7'd0, 16'h0000));
    send_item(make_item(scna_pkg::OP_FREE, 7'd1, 16'hFFFF));
    send_item(make_item(scna_pkg::OP_FREE, 7'd3, 16'hFFFE));
    send_item(make_item(scna_pkg::OP_FREE, 7'd12, 16'hFFFF));
    drain_results();

    rsv[0] = 16'd65200;
    rsv[1] = 16'd0;
    rsv[2] = 16'($urandom_range(64000, 65500));
    count[0] = 230;
    count[1] = 230;
    count[2] = 240;
    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 21; recv_idle_pct = 57; end
        1: begin send_idle_pct = 57; recv_idle_pct = 21; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      write_reserved(rsv[ph]);
      for (i = 0; i < count[ph]; i++) begin
        if (ph == 1 && i == count[ph] / 2) drain_results();
        send_item(random_request());
      end
      drain_results();
    end

    repeat (8) @(posedge clk);
    $display("Covered %0d requests over %0d reserved_words writes after reset.",
             tr.requests, tr.settings);
    $display("Status counts ok/oom/large/protected/double/mismatch: %0d/%0d/%0d/%0d/%0d/%0d",
             tr.status_seen[scna_pkg::STAT_OK], tr.status_seen[scna_pkg::STAT_OUT_OF_MEMORY],
             tr.status_seen[scna_pkg::STAT_NOT_RECLAIMED],
             tr.status_seen[scna_pkg::STAT_PROTECTED],
             tr.status_seen[scna_pkg::STAT_DOUBLE_FREE],
             tr.status_seen[scna_pkg::STAT_SIZE_MISMATCH]);
    if (tr.errors == 0) begin
      $display("size_class_node_allocator regression: pass");
    end else begin
      $display("size_class_node_allocator regression: fail");
    end
    $finish;
  end

  // Covers five clearing passes of the tag memory plus the traffic, several times over
  initial begin
    #25_000_000;
    $display("size_class_node_allocator regression: fail");
    $finish;
  end

endmodule
